FILE: rtl/tlt_pkg.sv
// Shared codes, character constants and keyword-match helpers for the tokenizer.
package tlt_pkg;

	// Scan mode codes
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_IDENT   = 3'd1;
	localparam logic [2:0] MODE_NUMBER  = 3'd2;
	localparam logic [2:0] MODE_SLASH   = 3'd3;
	localparam logic [2:0] MODE_COMMENT = 3'd4;

	// Token kind codes
	localparam logic [2:0] KIND_IDENT   = 3'd0;
	localparam logic [2:0] KIND_VAR     = 3'd1;
	localparam logic [2:0] KIND_PRINT   = 3'd2;
	localparam logic [2:0] KIND_NUMBER  = 3'd3;
	localparam logic [2:0] KIND_ASSIGN  = 3'd4;
	localparam logic [2:0] KIND_SEMI    = 3'd5;
	localparam logic [2:0] KIND_UNKNOWN = 3'd6;
	localparam logic [2:0] KIND_END     = 3'd7;

	// Input function codes
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_END  = 1'b1;

	// Characters with a meaning of their own
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_V     = 8'h76;

	// Keyword progress codes: "var" runs 1..3, "print" runs 4..8
	localparam logic [3:0] KW_NONE  = 4'd0;
	localparam logic [3:0] KW_V     = 4'd1;
	localparam logic [3:0] KW_VA    = 4'd2;
	localparam logic [3:0] KW_VAR   = 4'd3;
	localparam logic [3:0] KW_P     = 4'd4;
	localparam logic [3:0] KW_PR    = 4'd5;
	localparam logic [3:0] KW_PRI   = 4'd6;
	localparam logic [3:0] KW_PRIN  = 4'd7;
	localparam logic [3:0] KW_PRINT = 4'd8;

	// Result queue depth (power of two)
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	function automatic logic [3:0] kw_first(input logic [7:0] c);
		logic [3:0] r;
		r = KW_NONE;
		if (c == CH_V) r = KW_V;
		else if (c == CH_P) r = KW_P;
		return r;
	endfunction

	function automatic logic [3:0] kw_next(input logic [3:0] prog, input logic [7:0] c);
		logic [3:0] r;
		r = KW_NONE;
		unique case (prog)
			KW_V:    if (c == CH_LC_A) r = KW_VA;
			KW_VA:   if (c == CH_R) r = KW_VAR;
			KW_P:    if (c == CH_R) r = KW_PR;
			KW_PR:   if (c == CH_I) r = KW_PRI;
			KW_PRI:  if (c == CH_N) r = KW_PRIN;
			KW_PRIN: if (c == CH_T) r = KW_PRINT;
			default: r = KW_NONE;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/tlt_step.sv
// Scan state and per-byte token logic: consumes one item, produces up to two records.
module tlt_step
	import tlt_pkg::*;
#(
	parameter int OFFSET_BITS = 32,
	parameter int LENGTH_BITS = 16,
	parameter int REC_W = 1 + 3 + 8 + LENGTH_BITS + OFFSET_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,      // consume func/char this cycle
	input  logic             func,
	input  logic [7:0]       char_byte,
	output logic [1:0]       push_n,    // records produced this cycle
	output logic [REC_W-1:0] rec_a,     // {last, kind, char, length, start}
	output logic [REC_W-1:0] rec_b
);

	localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	logic [2:0]             mode_q, mode_d;
	logic [3:0]             kw_q, kw_d;
	logic [OFFSET_BITS-1:0] start_q, start_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic [OFFSET_BITS-1:0] off_q, off_d;

	logic                   is_space, is_alpha, is_digit, ident_cont;
	logic [LENGTH_BITS-1:0] len_grown;
	logic                   do_flush, take_byte, do_new, end_emit;
	logic [2:0]             new_kind;
	logic                   flush_v, sec_v;
	logic [2:0]             flush_kind;
	logic [LENGTH_BITS-1:0] flush_len;
	logic [7:0]             flush_ch;
	logic [REC_W-1:0]       flush_rec, sec_rec;

	// Classify the byte
	assign is_space = (char_byte == CH_SPACE) || (char_byte >= CH_TAB && char_byte <= CH_CR);
	assign is_alpha = (char_byte >= CH_LC_A && char_byte <= CH_LC_Z)
		|| (char_byte >= CH_UC_A && char_byte <= CH_UC_Z);
	assign is_digit = (char_byte >= CH_ZERO && char_byte <= CH_NINE);
	assign ident_cont = is_alpha || is_digit || char_byte == CH_LT || char_byte == CH_GT;
	assign len_grown = (len_q == LEN_MAX) ? len_q : len_q + LEN_ONE;

	// Advance the scan state
	always_comb begin
		mode_d    = mode_q;
		kw_d      = kw_q;
		start_d   = start_q;
		len_d     = len_q;
		off_d     = off_q;
		do_flush  = 1'b0;
		take_byte = 1'b0;
		do_new    = 1'b0;
		end_emit  = 1'b0;
		new_kind  = KIND_UNKNOWN;
		if (fire) begin
			if (func == FUNC_END) begin
				do_flush = 1'b1;
				end_emit = 1'b1;
				mode_d   = MODE_IDLE;
				kw_d     = KW_NONE;
				start_d  = '0;
				len_d    = '0;
				off_d    = '0;
			end else begin
				off_d = off_q + OFFSET_BITS'(1);
				unique case (mode_q)
					MODE_COMMENT: begin
						if (char_byte == CH_NL) mode_d = MODE_IDLE;
					end
					MODE_SLASH: begin
						if (char_byte == CH_SLASH) begin
							mode_d = MODE_COMMENT;
						end else begin
							do_flush  = 1'b1;
							take_byte = 1'b1;
						end
					end
					MODE_IDENT: begin
						if (ident_cont) begin
							len_d = len_grown;
							kw_d  = kw_next(kw_q, char_byte);
						end else begin
							do_flush  = 1'b1;
							take_byte = 1'b1;
						end
					end
					MODE_NUMBER: begin
						if (is_digit) begin
							len_d = len_grown;
						end else begin
							do_flush  = 1'b1;
							take_byte = 1'b1;
						end
					end
					default: take_byte = 1'b1;
				endcase
				if (take_byte) begin
					mode_d = MODE_IDLE;
					kw_d   = KW_NONE;
					priority if (is_space) begin
						mode_d = MODE_IDLE;
					end else if (char_byte == CH_SLASH) begin
						mode_d  = MODE_SLASH;
						start_d = off_q;
						len_d   = LEN_ONE;
					end else if (is_alpha) begin
						mode_d  = MODE_IDENT;
						start_d = off_q;
						len_d   = LEN_ONE;
						kw_d    = kw_first(char_byte);
					end else if (is_digit) begin
						mode_d  = MODE_NUMBER;
						start_d = off_q;
						len_d   = LEN_ONE;
					end else if (char_byte == CH_EQ) begin
						do_new   = 1'b1;
						new_kind = KIND_ASSIGN;
					end else if (char_byte == CH_SEMI) begin
						do_new   = 1'b1;
						new_kind = KIND_SEMI;
					end else begin
						do_new   = 1'b1;
						new_kind = KIND_UNKNOWN;
					end
				end
			end
		end
	end

	// Describe the token being closed
	always_comb begin
		flush_v    = 1'b0;
		flush_kind = KIND_IDENT;
		flush_len  = len_q;
		flush_ch   = 8'h00;
		if (do_flush) begin
			unique case (mode_q)
				MODE_IDENT: begin
					flush_v = 1'b1;
					if (kw_q == KW_VAR) flush_kind = KIND_VAR;
					else if (kw_q == KW_PRINT) flush_kind = KIND_PRINT;
					else flush_kind = KIND_IDENT;
				end
				MODE_NUMBER: begin
					flush_v    = 1'b1;
					flush_kind = KIND_NUMBER;
				end
				MODE_SLASH: begin
					flush_v    = 1'b1;
					flush_kind = KIND_UNKNOWN;
					flush_len  = LEN_ONE;
					flush_ch   = CH_SLASH;
				end
				default: flush_v = 1'b0;
			endcase
		end
	end

	// Pack the records in emission order
	assign sec_v = end_emit || do_new;
	assign flush_rec = {!sec_v, flush_kind, flush_ch, flush_len, start_q};
	assign sec_rec = end_emit ? {1'b1, KIND_END, 8'h00, {LENGTH_BITS{1'b0}}, off_q}
		: {1'b1, new_kind, char_byte, LEN_ONE, off_q};

	always_comb begin
		if (flush_v) begin
			rec_a  = flush_rec;
			rec_b  = sec_rec;
			push_n = sec_v ? 2'd2 : 2'd1;
		end else begin
			rec_a  = sec_rec;
			rec_b  = sec_rec;
			push_n = sec_v ? 2'd1 : 2'd0;
		end
	end

	// Hold the scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			kw_q    <= KW_NONE;
			start_q <= '0;
			len_q   <= '0;
			off_q   <= '0;
		end else begin
			mode_q  <= mode_d;
			kw_q    <= kw_d;
			start_q <= start_d;
			len_q   <= len_d;
			off_q   <= off_d;
		end
	end

`ifndef SYNTHESIS
	a_end_clears_offset: assert property (@(posedge clk) disable iff (!arst_n)
		fire && func == FUNC_END |=> off_q == '0 && mode_q == MODE_IDLE)
		else $error("end of text did not clear the offset and mode");
	a_comment_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && func == FUNC_BYTE && mode_q == MODE_COMMENT |-> push_n == 2'd0)
		else $error("comment byte produced a token");
	a_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		fire && func == FUNC_END |-> push_n != 2'd0)
		else $error("end of text produced no record");
`endif

endmodule

FILE: rtl/tlt_out_queue.sv
// Small result queue: takes up to two records a cycle, hands out one.
module tlt_out_queue
	import tlt_pkg::*;
#(
	parameter int WIDTH = 60
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_n,
	input  logic [WIDTH-1:0] push_a,
	input  logic [WIDTH-1:0] push_b,
	output logic             room2,     // space for two more records
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_rec
);

	localparam logic [Q_PTR_W:0] DEPTH_C = (Q_PTR_W + 1)'(Q_DEPTH);

	logic [WIDTH-1:0]   mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [Q_PTR_W:0]   count_q;
	logic               pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_rec   = mem_q[rd_ptr_q];
	assign room2     = (count_q <= DEPTH_C - (Q_PTR_W + 1)'(2));
	assign wr_ptr_nx = wr_ptr_q + Q_PTR_W'(1);

	// Store incoming records
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_ptr_q] <= push_a;
		if (push_n == 2'd2) mem_q[wr_ptr_nx] <= push_b;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_PTR_W'(push_n);
			if (pop) rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			count_q <= count_q + (Q_PTR_W + 1)'(push_n) - (Q_PTR_W + 1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> room2)
		else $error("result queue written without room");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("result queue count out of range");
`endif

endmodule

FILE: rtl/tiny_language_tokenizer.sv
// Top level of the streaming tokenizer: input register, scan logic, result queue.
// Text bytes (s_tuser = 0) or an end-of-text mark (s_tuser = 1) enter one item per
// clock while s_tready is high; each byte is registered, then scanned against the
// held mode, keyword progress and offset once the queue has room, and the records
// it closes (none, one or two) go into a four-entry result queue that drives the
// output. Input is taken every cycle while the queue has room for two records, so
// the sustained input rate is one byte per cycle as long as the output keeps pace;
// text that closes a token on nearly every byte is limited by the output taking one
// record per cycle. Records reach the output via the input register and the queue.
// Records carry kind, start offset, saturating length and, for one-byte tokens,
// the byte; m_tlast marks the last record caused by one input item. End of text
// flushes the open token, sends an end record and restarts offsets at zero.
module tiny_language_tokenizer
	import tlt_pkg::*;
#(
	parameter int OFFSET_BITS = 32,
	parameter int LENGTH_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] char_byte
	input  logic       s_tuser,    // [0] func
	output logic       m_tvalid,
	input  logic       m_tready,
	// [OFFSET_BITS-1:0] token_start, then token_length, then token_char, zero fill
	output logic [((OFFSET_BITS + LENGTH_BITS + 8 + 7) / 8) * 8 - 1:0] m_tdata,
	output logic [2:0] m_tuser,    // [2:0] token_kind
	output logic       m_tlast     // last_of_run
);

	localparam int REC_W    = 1 + 3 + 8 + LENGTH_BITS + OFFSET_BITS;
	localparam int TDATA_W  = ((OFFSET_BITS + LENGTH_BITS + 8 + 7) / 8) * 8;
	localparam int LEN_LO   = OFFSET_BITS;
	localparam int CH_LO    = OFFSET_BITS + LENGTH_BITS;
	localparam int KIND_LO  = CH_LO + 8;
	localparam int LAST_BIT = KIND_LO + 3;

	logic             valid_s1;
	logic             func_s1;
	logic [7:0]       char_s1;
	logic             fire;
	logic             room2;
	logic [1:0]       push_n;
	logic [REC_W-1:0] rec_a, rec_b, out_rec;

	// Scan the held item when the queue can take its records
	assign fire     = valid_s1 && room2;
	assign s_tready = !valid_s1 || fire;

	// Hold the input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tuser;
			char_s1 <= s_tdata;
		end
	end

	tlt_step #(
		.OFFSET_BITS(OFFSET_BITS),
		.LENGTH_BITS(LENGTH_BITS),
		.REC_W(REC_W)
	) u_step (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.func(func_s1),
		.char_byte(char_s1),
		.push_n(push_n),
		.rec_a(rec_a),
		.rec_b(rec_b)
	);

	tlt_out_queue #(
		.WIDTH(REC_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_n(push_n),
		.push_a(rec_a),
		.push_b(rec_b),
		.room2(room2),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_rec(out_rec)
	);

	// Unpack the record onto the stream
	assign m_tdata = TDATA_W'(out_rec[KIND_LO-1:0]);
	assign m_tuser = out_rec[LAST_BIT-1:KIND_LO];
	assign m_tlast = out_rec[LAST_BIT];

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with an empty input register");
	a_push_only_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |-> push_n == 2'd0)
		else $error("records produced without a scanned item");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the streaming tokenizer: random text in, token records out.
module tb;
	import tlt_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int PHASE_ITEMS   = 110;
	localparam int HOLD_CYCLES   = 400;
	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	// Expected token records and the scan state that produces them
	class token_board;
		typedef struct {
			logic [2:0]  kind;
			logic [31:0] start;
			logic [15:0] len;
			logic [7:0]  ch;
			logic        last;
		} token_rec_t;

		token_rec_t  expected_tokens[$];
		logic [2:0]  scan_state  = MODE_IDLE;
		logic [3:0]  kw_state    = KW_NONE;
		logic [31:0] tok_start   = '0;
		logic [15:0] tok_len     = '0;
		logic [31:0] text_pos    = '0;
		int          errors      = 0;

		function int outstanding();
			return expected_tokens.size();
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) $display("mismatch: %s", msg);
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		endfunction

		function bit is_letter(logic [7:0] c);
			return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
		endfunction

		function bit is_numeral(logic [7:0] c);
			return c >= CH_ZERO && c <= CH_NINE;
		endfunction

		// Letter that continues a keyword prefix, zero where none does
		function logic [7:0] kw_wanted(logic [3:0] prog);
			case (prog)
				KW_V:    return CH_LC_A;
				KW_VA:   return CH_R;
				KW_P:    return CH_R;
				KW_PR:   return CH_I;
				KW_PRI:  return CH_N;
				KW_PRIN: return CH_T;
				default: return 8'h00;
			endcase
		endfunction

		function void push_token(logic [2:0] kind, logic [31:0] start, logic [15:0] len,
				logic [7:0] ch);
			token_rec_t rec;
			rec.kind = kind;
			rec.start = start;
			rec.len = len;
			rec.ch = ch;
			rec.last = 1'b0;
			expected_tokens.insert(expected_tokens.size(), rec);
		endfunction

		// Emit whatever token is open and return to idle
		function void close_open();
			logic [2:0] kind;
			if (scan_state == MODE_IDENT) begin
				kind = KIND_IDENT;
				if (kw_state == KW_VAR) kind = KIND_VAR;
				else if (kw_state == KW_PRINT) kind = KIND_PRINT;
				push_token(kind, tok_start, tok_len, 8'h00);
			end else if (scan_state == MODE_NUMBER) begin
				push_token(KIND_NUMBER, tok_start, tok_len, 8'h00);
			end else if (scan_state == MODE_SLASH) begin
				push_token(KIND_UNKNOWN, tok_start, 16'd1, CH_SLASH);
			end
			scan_state = MODE_IDLE;
			kw_state = KW_NONE;
		endfunction

		// Start a token on a byte seen from idle
		function void open_byte(logic [7:0] c, logic [31:0] pos);
			if (is_blank(c)) begin
				return;
			end else if (c == CH_SLASH || is_letter(c) || is_numeral(c)) begin
				tok_start = pos;
				tok_len = 16'd1;
				if (c == CH_SLASH) begin
					scan_state = MODE_SLASH;
				end else if (is_letter(c)) begin
					scan_state = MODE_IDENT;
					kw_state = (c == CH_V) ? KW_V : (c == CH_P) ? KW_P : KW_NONE;
				end else begin
					scan_state = MODE_NUMBER;
				end
			end else if (c == CH_EQ) begin
				push_token(KIND_ASSIGN, pos, 16'd1, c);
			end else if (c == CH_SEMI) begin
				push_token(KIND_SEMI, pos, 16'd1, c);
			end else begin
				push_token(KIND_UNKNOWN, pos, 16'd1, c);
			end
		endfunction

		// Scan one accepted item and queue the records it closes
		function void take_item(logic func, logic [7:0] c);
			int          count_in;
			logic [31:0] pos;
			logic [7:0]  want;
			count_in = expected_tokens.size();
			pos = text_pos;
			if (func == FUNC_END) begin
				if (scan_state == MODE_COMMENT) scan_state = MODE_IDLE;
				close_open();
				push_token(KIND_END, pos, 16'd0, 8'h00);
				text_pos = '0;
				tok_start = '0;
				tok_len = '0;
			end else begin
				text_pos = text_pos + 32'd1;
				if (scan_state == MODE_COMMENT) begin
					if (c == CH_NL) scan_state = MODE_IDLE;
				end else if (scan_state == MODE_SLASH && c == CH_SLASH) begin
					scan_state = MODE_COMMENT;
				end else if (scan_state == MODE_IDENT &&
						(is_letter(c) || is_numeral(c) || c == CH_LT || c == CH_GT)) begin
					if (tok_len != LEN_MAX) tok_len++;
					want = kw_wanted(kw_state);
					kw_state = (want != 8'h00 && c == want) ? kw_state + 4'd1 : KW_NONE;
				end else if (scan_state == MODE_NUMBER && is_numeral(c)) begin
					if (tok_len != LEN_MAX) tok_len++;
				end else begin
					close_open();
					open_byte(c, pos);
				end
			end
			if (expected_tokens.size() > count_in)
				expected_tokens[expected_tokens.size() - 1].last = 1'b1;
		endfunction

		// Compare one accepted record with the oldest expectation
		function void check_token(logic [2:0] kind, logic [31:0] start, logic [15:0] len,
				logic [7:0] ch, logic last);
			token_rec_t want;
			if (expected_tokens.size() == 0) begin
				flag($sformatf("unexpected token kind %0d start %0d len %0d char %02h last %0b",
					kind, start, len, ch, last));
				return;
			end
			want = expected_tokens.pop_front();
			if (want.kind !== kind || want.start !== start || want.len !== len ||
					want.ch !== ch || want.last !== last)
				flag($sformatf({"expected kind %0d start %0d len %0d char %02h last %0b, ",
					"got kind %0d start %0d len %0d char %02h last %0b"},
					want.kind, want.start, want.len, want.ch, want.last,
					kind, start, len, ch, last));
		endfunction

		function void close_out();
			if (expected_tokens.size() != 0)
				flag($sformatf("%0d tokens never arrived", expected_tokens.size()));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tuser = FUNC_BYTE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	token_board board = new();
	int tx_gap_max = 0;
	int rx_stall_max = 0;
	int rx_hold = 0;
	int items_sent = 0;
	int cycle_count = 0;

	tiny_language_tokenizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** tiny_language_tokenizer: FAILED **");
			$finish;
		end
	end

	// Offer one item after a random gap; called and returns at a falling edge
	task automatic send_item(input logic func, input logic [7:0] c);
		int gap;
		gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
		for (int k = 0; k < gap; k++) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= c;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		board.take_item(func, c);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_item(FUNC_BYTE, s[i]);
	endtask

	// Hold input off until every expected token has come back
	task automatic drain_tokens();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (board.outstanding() != 0) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_letter();
		logic [7:0] c;
		c = 8'($urandom_range(0, 25));
		return $urandom_range(0, 1) ? CH_LC_A + c : CH_UC_A + c;
	endfunction

	function automatic logic [7:0] pick_ident_tail();
		case ($urandom_range(0, 5))
			0:       return CH_ZERO + 8'($urandom_range(0, 9));
			1:       return $urandom_range(0, 1) ? CH_LT : CH_GT;
			default: return pick_letter();
		endcase
	endfunction

	// Send one mostly well-formed piece of program text
	task automatic send_chunk();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			case ($urandom_range(0, 3))
				0: send_text("var");
				1: send_text("print");
				2: send_text("va");
				default: send_text("prin");
			endcase
			if ($urandom_range(0, 2) == 0) send_item(FUNC_BYTE, pick_ident_tail());
		end else if (r < 38) begin
			send_item(FUNC_BYTE, pick_letter());
			n = $urandom_range(0, 6);
			for (int i = 0; i < n; i++) send_item(FUNC_BYTE, pick_ident_tail());
		end else if (r < 52) begin
			n = $urandom_range(1, 5);
			for (int i = 0; i < n; i++) send_item(FUNC_BYTE, CH_ZERO + 8'($urandom_range(0, 9)));
		end else if (r < 68) begin
			case ($urandom_range(0, 5))
				0: send_item(FUNC_BYTE, CH_EQ);
				1: send_item(FUNC_BYTE, CH_SEMI);
				2: send_item(FUNC_BYTE, CH_SLASH);
				3: send_item(FUNC_BYTE, CH_NL);
				4: send_item(FUNC_BYTE, 8'($urandom_range(9, 13)));
				default: send_item(FUNC_BYTE, CH_SPACE);
			endcase
		end else if (r < 76) begin
			send_text("//");
			n = $urandom_range(0, 6);
			for (int i = 0; i < n; i++) send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
			send_item(FUNC_BYTE, CH_NL);
		end else if (r < 86) begin
			send_item(FUNC_BYTE, CH_SPACE);
		end else if (r < 97) begin
			send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
		end else begin
			send_item(FUNC_END, 8'($urandom_range(0, 255)));
		end
	endtask

	// Accept and check token records, with random stalls and an occasional long hold
	initial begin
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			for (int k = 0; k < rx_hold; k++) begin
				m_tready <= 1'b0;
				@(negedge clk);
			end
			rx_hold = 0;
			for (int k = (rx_stall_max > 0) ? $urandom_range(0, rx_stall_max) : 0; k > 0; k--) begin
				m_tready <= 1'b0;
				@(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			board.check_token(m_tuser, m_tdata[31:0], m_tdata[47:32], m_tdata[55:48], m_tlast);
			@(negedge clk);
		end
	end

	// Stimulus
	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Keywords, near-keywords, one-byte tokens, single slash, comment, odd bytes
		send_text("var print pri=7;/a//c\n5");
		send_item(FUNC_BYTE, 8'hFF);
		send_item(FUNC_BYTE, 8'h00);
		send_item(FUNC_END, 8'h00);
		// Pending slash and an open comment flushed by end of text
		send_text("q/");
		send_item(FUNC_END, 8'hFF);
		send_text("//");
		send_item(FUNC_END, 8'h5A);
		drain_tokens();

		// Stall the output for a long stretch while bytes keep coming
		rx_stall_max = 0;
		tx_gap_max = 0;
		rx_hold = HOLD_CYCLES;
		for (int i = 0; i < 40; i++) send_item(FUNC_BYTE, (i % 2) ? CH_SEMI : CH_EQ);
		drain_tokens();

		// Random text under changing idle patterns
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin tx_gap_max = 0;  rx_stall_max = 0;  end
				1: begin tx_gap_max = 14; rx_stall_max = 14; end
				2: begin tx_gap_max = 0;  rx_stall_max = 14; end
				3: begin tx_gap_max = 14; rx_stall_max = 0;  end
				4: begin tx_gap_max = 3;  rx_stall_max = 3;  end
				default: begin tx_gap_max = 14; rx_stall_max = 14; end
			endcase
			items_sent = 0;
			while (items_sent < PHASE_ITEMS) send_chunk();
			if (phase == 2) drain_tokens();
		end
		send_item(FUNC_END, 8'h00);

		// Wait out the last tokens
		s_tvalid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		board.close_out();
		if (board.errors == 0)
			$display("** tiny_language_tokenizer: PASSED **");
		else
			$display("** tiny_language_tokenizer: FAILED **");
		$finish;
	end

endmodule

FILE: tiny_language_tokenizer.f
rtl/tlt_pkg.sv
rtl/tlt_step.sv
rtl/tlt_out_queue.sv
rtl/tiny_language_tokenizer.sv
tb/tb.sv
